@@ rtl/tcw_pkg.sv @@
// Shared types, constants and helpers for the text console writer.
// Used by tcw_ctrl, tcw_dpath and text_console_writer; depends on nothing.
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);

    // Field widths.
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 2 * CHAR_W;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Character and attribute codes.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CELL_AW-1:0] LAST_ROW_BASE  = CELL_AW'(CELLS - COLUMNS);
    localparam logic [CELL_AW-1:0] LAST_CELL      = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] LAST_COPY_CELL = CELL_AW'(CELLS - COLUMNS - 1);

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } req_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_color;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } rsp_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;
        logic sweep_init;
        logic sweep_from_last_row;
        logic fill;
        logic fill_reset_color;
        logic copy_rd;
        logic read_cell;
        logic capture_cell;
        logic char_write;
        logic cur_home;
        logic cur_next_row;
        logic cur_col_zero;
        logic load_result;
    } tcw_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             is_newline;
        logic             col_at_width;
        logic             row_last;
        logic             sweep_last;
        logic             copy_last;
        logic             out_free;
        logic             copy_wr_pending;
    } tcw_status_t;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [CELL_AW-1:0] base;
        base = CELL_AW'(row) * CELL_AW'(COLUMNS);
        return CELL_AW'(base + CELL_AW'(col));
    endfunction

endpackage

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/tcw_ctrl.sv @@
// Sequencing state machine of the text console writer.
// Depends on tcw_pkg for the command and status structs and request codes.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_RESET_FILL,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_FILL,
        ST_WRITE_CHAR,
        ST_READ_WAIT,
        ST_CLEAR_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_RESET_FILL:
            begin
                cmd.fill             = 1'b1;
                cmd.fill_reset_color = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.req_type)
                    tcw_pkg::REQ_PUT:
                    begin
                        if (status.is_newline || status.col_at_width)
                        begin
                            if (status.row_last)
                            begin
                                cmd.sweep_init = 1'b1;
                                state_next     = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                cmd.cur_next_row = 1'b1;
                                state_next = status.is_newline ? ST_DONE : ST_WRITE_CHAR;
                            end
                        end
                        else
                        begin
                            state_next = ST_WRITE_CHAR;
                        end
                    end
                    tcw_pkg::REQ_READ:
                    begin
                        cmd.read_cell = 1'b1;
                        state_next    = ST_READ_WAIT;
                    end
                    tcw_pkg::REQ_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = ST_CLEAR_FILL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCROLL_COPY:
            begin
                cmd.copy_rd = 1'b1;
                if (status.copy_last)
                begin
                    state_next = ST_SCROLL_DRAIN;
                end
            end
            ST_SCROLL_DRAIN:
            begin
                // last copied cell is written this cycle
                cmd.sweep_init          = 1'b1;
                cmd.sweep_from_last_row = 1'b1;
                state_next              = ST_SCROLL_FILL;
            end
            ST_SCROLL_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.cur_col_zero = 1'b1;
                    state_next = status.is_newline ? ST_DONE : ST_WRITE_CHAR;
                end
            end
            ST_WRITE_CHAR:
            begin
                cmd.char_write = 1'b1;
                state_next     = ST_DONE;
            end
            ST_READ_WAIT:
            begin
                cmd.capture_cell = 1'b1;
                state_next       = ST_DONE;
            end
            ST_CLEAR_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.cur_home = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tcw_dpath.sv @@
// Datapath of the text console writer: request and cursor registers, sweep
// counter, screen RAM and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcw_pkg::req_item_t              req_data,
    input  logic [tcw_pkg::CHAR_W-1:0]      text_color,
    input  tcw_pkg::tcw_cmd_t               cmd,
    output tcw_pkg::tcw_status_t            status,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tcw_pkg::rsp_item_t              rsp_data
);

    tcw_pkg::req_item_t                 req_reg;
    logic [tcw_pkg::ROW_W-1:0]          cursor_row_reg;
    logic [tcw_pkg::COL_W-1:0]          cursor_col_reg;
    logic [tcw_pkg::CELL_AW-1:0]        sweep_idx_reg;
    logic                               copy_wr_pending_reg;
    logic [tcw_pkg::CELL_AW-1:0]        copy_wr_addr_reg;
    logic [tcw_pkg::CELL_W-1:0]         cell_reg;
    logic                               rsp_valid_reg;
    tcw_pkg::rsp_item_t                 rsp_data_reg;

    logic                               read_in_range;
    logic [tcw_pkg::CELL_AW-1:0]        cursor_addr;
    logic [tcw_pkg::CELL_AW-1:0]        read_addr;
    logic [tcw_pkg::CHAR_W-1:0]         fill_color;
    logic                               ram_we;
    logic [tcw_pkg::CELL_AW-1:0]        ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [tcw_pkg::CELL_AW-1:0]        ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]         ram_rdata;

    assign read_in_range = (req_reg.read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                        && (req_reg.read_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    assign cursor_addr = tcw_pkg::cell_addr(cursor_row_reg, cursor_col_reg);
    assign read_addr   = tcw_pkg::cell_addr(req_reg.read_row, req_reg.read_col);
    assign fill_color  = cmd.fill_reset_color ? tcw_pkg::RESET_COLOR : text_color;

    // Write port: pending scroll copy first, then fills, then a character.
    always_comb
    begin
        ram_we = copy_wr_pending_reg || cmd.fill || cmd.char_write;
        if (copy_wr_pending_reg)
        begin
            ram_waddr = copy_wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.fill)
        begin
            ram_waddr = sweep_idx_reg;
            ram_wdata = {tcw_pkg::SPACE_CODE, fill_color};
        end
        else
        begin
            ram_waddr = cursor_addr;
            ram_wdata = {req_reg.char_code, text_color};
        end
    end

    assign ram_re    = cmd.copy_rd || (cmd.read_cell && read_in_range);
    assign ram_raddr = cmd.copy_rd
                     ? tcw_pkg::CELL_AW'(sweep_idx_reg + tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS))
                     : read_addr;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg      <= '0;
            cursor_col_reg      <= '0;
            sweep_idx_reg       <= '0;
            copy_wr_pending_reg <= 1'b0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            // cursor
            if (cmd.cur_home)
            begin
                cursor_row_reg <= '0;
                cursor_col_reg <= '0;
            end
            else if (cmd.cur_next_row)
            begin
                cursor_row_reg <= cursor_row_reg + 1'b1;
                cursor_col_reg <= '0;
            end
            else if (cmd.cur_col_zero)
            begin
                cursor_col_reg <= '0;
            end
            else if (cmd.char_write)
            begin
                cursor_col_reg <= cursor_col_reg + 1'b1;
            end

            // sweep counter
            if (cmd.sweep_init)
            begin
                sweep_idx_reg <= cmd.sweep_from_last_row ? tcw_pkg::LAST_ROW_BASE : '0;
            end
            else if (cmd.fill || cmd.copy_rd)
            begin
                sweep_idx_reg <= (sweep_idx_reg == tcw_pkg::LAST_CELL)
                               ? '0 : sweep_idx_reg + 1'b1;
            end

            // copy write lands in the cycle after its read
            copy_wr_pending_reg <= cmd.copy_rd;

            // result handshake
            if (cmd.load_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.copy_rd)
        begin
            copy_wr_addr_reg <= sweep_idx_reg;
        end
        if (cmd.load_req)
        begin
            cell_reg <= '0;
        end
        else if (cmd.capture_cell)
        begin
            cell_reg <= read_in_range ? ram_rdata : '0;
        end
        if (cmd.load_result)
        begin
            rsp_data_reg.cell_char  <= cell_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            rsp_data_reg.cell_color <= cell_reg[tcw_pkg::CHAR_W-1:0];
            rsp_data_reg.cursor_row <= cursor_row_reg;
            rsp_data_reg.cursor_col <= cursor_col_reg;
        end
    end

    always_comb
    begin
        status.req_type        = req_reg.req_type;
        status.is_newline      = (req_reg.char_code == tcw_pkg::NEWLINE_CODE);
        status.col_at_width    = (cursor_col_reg >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
        status.row_last        = (cursor_row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        status.sweep_last      = (sweep_idx_reg == tcw_pkg::LAST_CELL);
        status.copy_last       = (sweep_idx_reg == tcw_pkg::LAST_COPY_CELL);
        status.out_free        = !rsp_valid_reg || !rsp_stall;
        status.copy_wr_pending = copy_wr_pending_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: configuration port, controller and
// datapath. Depends on tcw_pkg, tcw_ctrl, tcw_dpath (and through it tcw_ram).

// Character-cell text console with an 80 x 25 screen held in a 2000 x 16 RAM
// (character in the upper byte, attribute in the lower byte) and a cursor.
// Requests arrive one transaction at a time on the req channel; each returns
// exactly one transaction on the rsp channel carrying the read cell (zero
// unless it is an in-range read) and the cursor after the request. The block
// handles one request at a time: a printable character or a read passes
// through dispatch, a write or read-wait state and a done state; a newline
// that stays above the last row goes from dispatch straight to done; a newline
// or wrap on the last row scrolls the screen (a copy of each row below the
// first up by one, a drain state, then a blank of the last row); and a clear
// screen writes every cell once. After reset the block runs a clearing pass
// that fills the screen with spaces in attribute 7 and holds req_stall high
// meanwhile; configuration writes are taken throughout. A finished result
// waits in the output register while the next request is accepted. The
// text_color register sits at byte address 0 of the APB port and colors
// written characters and the blanks of scrolls and clears.
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  tcw_pkg::req_item_t            req_data,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output tcw_pkg::rsp_item_t            rsp_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::APB_AW-1:0]    paddr,
    input  logic [tcw_pkg::APB_DW-1:0]    pwdata,
    output logic [tcw_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [tcw_pkg::CHAR_W-1:0] text_color_reg;
    logic                       color_sel;
    tcw_pkg::tcw_cmd_t          cmd;
    tcw_pkg::tcw_status_t       status;

    // Only word 0 holds a register; higher words read zero and drop writes.
    assign color_sel = (paddr[tcw_pkg::APB_AW-1] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = color_sel ? tcw_pkg::APB_DW'(text_color_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (psel && penable && pwrite && pready && color_sel)
        begin
            text_color_reg <= pwdata[tcw_pkg::CHAR_W-1:0];
        end
    end

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_data   (req_data),
        .text_color (text_color_reg),
        .cmd        (cmd),
        .status     (status),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

    // One request in flight: an accepted transaction closes the request side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    // The screen RAM write port never has two sources in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({status.copy_wr_pending, cmd.fill, cmd.char_write}))
        else $error("screen RAM write port conflict");

    // A result is loaded only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> status.out_free)
        else $error("result overwrote an untaken transaction");

    // The reported cursor stays on screen; the column may sit at the width.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_data.cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                    && (rsp_data.cursor_col <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS))))
        else $error("cursor reported off screen");

endmodule

@@ test/text_console_writer_test.sv @@
// Self-checking testbench for the text console writer: random and directed console requests,
// a console predictor, and text_color writes over the APB port.
// Depends on tcw_pkg and text_console_writer from the rtl folder.
module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused request code; the block must leave its state alone for it.
    localparam logic [tcw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Register map: text_color is register 0, one 32-bit word per register.
    localparam int REG_TEXT_COLOR = 0;
    localparam logic [tcw_pkg::APB_AW-1:0] TEXT_COLOR_ADDR =
        tcw_pkg::APB_AW'(4 * REG_TEXT_COLOR);

    // Row and column values used by the directed requests.
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_ZERO = '0;
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_ONE  = tcw_pkg::ROW_W'(1);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_OFF  = tcw_pkg::ROW_W'(tcw_pkg::ROWS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_MAX  = '1;
    localparam logic [tcw_pkg::COL_W-1:0] COL_ZERO = '0;
    localparam logic [tcw_pkg::COL_W-1:0] COL_ONE  = tcw_pkg::COL_W'(1);
    localparam logic [tcw_pkg::COL_W-1:0] COL_FOUR = tcw_pkg::COL_W'(4);
    localparam logic [tcw_pkg::COL_W-1:0] COL_LAST = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] COL_OFF  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::COL_W-1:0] COL_MAX  = '1;

    // A scroll or a clear walks the whole store; allow that for every
    // transaction plus both sides' longest pauses, then several times over.
    localparam int unsigned MAX_CYCLES   = 20_000_000;
    localparam int          DRAIN_CYCLES = 2100;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 180;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    tcw_pkg::req_item_t    req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    tcw_pkg::rsp_item_t    rsp_data;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [tcw_pkg::APB_AW-1:0]     paddr   = '0;
    logic [tcw_pkg::APB_DW-1:0]     pwdata  = '0;
    logic [tcw_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    text_console_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Console predictor: a private copy of the screen, cursor and color.
    // ------------------------------------------------------------------
    logic [tcw_pkg::CHAR_W-1:0] screen_chars [tcw_pkg::CELLS];
    logic [tcw_pkg::CHAR_W-1:0] screen_attrs [tcw_pkg::CELLS];
    int unsigned                cur_row;
    int unsigned                cur_col;
    logic [tcw_pkg::CHAR_W-1:0] attr_reg;

    // Statistics for the closing summary.
    int n_puts, n_newlines, n_reads, n_reads_off, n_clears, n_unused;
    int n_scrolls, n_wraps, n_colors;
    int err_count = 0;

    function automatic void blank_line(input int unsigned row);
        for (int c = 0; c < tcw_pkg::COLUMNS; c++)
        begin
            screen_chars[row * tcw_pkg::COLUMNS + c] = tcw_pkg::SPACE_CODE;
            screen_attrs[row * tcw_pkg::COLUMNS + c] = attr_reg;
        end
    endfunction

    function automatic void wipe_screen();
        for (int r = 0; r < tcw_pkg::ROWS; r++)
            blank_line(r);
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Move to column 0 of the next row; on the last row shift every row up and blank the last.
    function automatic void line_feed();
        if (cur_row < tcw_pkg::ROWS - 1)
            cur_row++;
        else
        begin
            for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
            begin
                screen_chars[i] = screen_chars[i + tcw_pkg::COLUMNS];
                screen_attrs[i] = screen_attrs[i + tcw_pkg::COLUMNS];
            end
            blank_line(tcw_pkg::ROWS - 1);
            n_scrolls++;
        end
        cur_col = 0;
    endfunction

    // Apply one request to the private console and return the result it must produce.
    function automatic tcw_pkg::rsp_item_t console_apply(input tcw_pkg::req_item_t req);
        tcw_pkg::rsp_item_t res;
        int unsigned idx;
        res = '0;
        case (req.req_type)
            tcw_pkg::REQ_PUT:
            begin
                n_puts++;
                if (req.char_code == tcw_pkg::NEWLINE_CODE)
                begin
                    n_newlines++;
                    line_feed();
                end
                else
                begin
                    // Wrap pending: the column sits at the width, so break the line first.
                    if (cur_col >= tcw_pkg::COLUMNS)
                    begin
                        n_wraps++;
                        line_feed();
                    end
                    idx = cur_row * tcw_pkg::COLUMNS + cur_col;
                    screen_chars[idx] = req.char_code;
                    screen_attrs[idx] = attr_reg;
                    cur_col++;
                end
            end
            tcw_pkg::REQ_READ:
            begin
                n_reads++;
                if (req.read_row < tcw_pkg::ROWS && req.read_col < tcw_pkg::COLUMNS)
                begin
                    idx = req.read_row * tcw_pkg::COLUMNS + req.read_col;
                    res.cell_char  = screen_chars[idx];
                    res.cell_color = screen_attrs[idx];
                end
                else
                    n_reads_off++;
            end
            tcw_pkg::REQ_CLEAR:
            begin
                n_clears++;
                wipe_screen();
            end
            default:
                n_unused++;
        endcase
        res.cursor_row = tcw_pkg::ROW_W'(cur_row);
        res.cursor_col = tcw_pkg::COL_W'(cur_col);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pacing: every transaction draws a random pause on each side,
    // except in calm phases, which run both channels back to back.
    // ------------------------------------------------------------------
    bit calm_pacing = 1'b0;

    function automatic int draw_pause();
        if (calm_pacing)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pops the pending queue, holds each request until the
    // block takes it, and predicts the result at the accepting edge.
    // ------------------------------------------------------------------
    tcw_pkg::req_item_t pending_reqs [$];
    tcw_pkg::rsp_item_t expected_rsps [$];
    int                 send_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_hold = 0;
        end
        else if (!(req_valid && req_stall))
        begin
            // Not stalled: either the line was idle or the current transaction went through.
            if (req_valid)
            begin
                expected_rsps.push_back(console_apply(req_data));
                send_hold = draw_pause();
            end
            if (send_hold == 0 && pending_reqs.size() != 0)
            begin
                req_data  <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
                if (send_hold > 0)
                    send_hold--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stalls at random while a result is offered and checks
    // every accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    tcw_pkg::rsp_item_t want_rsp;
    int                 recv_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result transaction: %h", rsp_data);
                    err_count++;
                end
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp_data.cell_char !== want_rsp.cell_char)
                    begin
                        $error("cell_char: expected %0d, got %0d",
                               want_rsp.cell_char, rsp_data.cell_char);
                        err_count++;
                    end
                    if (rsp_data.cell_color !== want_rsp.cell_color)
                    begin
                        $error("cell_color: expected %0d, got %0d",
                               want_rsp.cell_color, rsp_data.cell_color);
                        err_count++;
                    end
                    if (rsp_data.cursor_row !== want_rsp.cursor_row)
                    begin
                        $error("cursor_row: expected %0d, got %0d",
                               want_rsp.cursor_row, rsp_data.cursor_row);
                        err_count++;
                    end
                    if (rsp_data.cursor_col !== want_rsp.cursor_col)
                    begin
                        $error("cursor_col: expected %0d, got %0d",
                               want_rsp.cursor_col, rsp_data.cursor_col);
                        err_count++;
                    end
                end
                recv_hold = draw_pause();
            end
            else if (rsp_valid && recv_hold > 0)
                recv_hold--;
            // Stall only runs down while a result is actually on offer.
            rsp_stall <= (recv_hold > 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    int stim_count = 0;

    function automatic void push_item(input logic [tcw_pkg::REQ_W-1:0]  kind,
                                      input logic [tcw_pkg::CHAR_W-1:0] code,
                                      input logic [tcw_pkg::ROW_W-1:0]  row,
                                      input logic [tcw_pkg::COL_W-1:0]  col);
        tcw_pkg::req_item_t item;
        item.req_type  = kind;
        item.char_code = code;
        item.read_row  = row;
        item.read_col  = col;
        pending_reqs.push_back(item);
        // The unused code is ignored by the block, so it does not count as stimulus.
        if (kind != REQ_UNUSED)
            stim_count++;
    endfunction

    // Mostly on-screen reads with a bias to the last row, plus some off-screen ones.
    function automatic void queue_read();
        int pick;
        logic [tcw_pkg::ROW_W-1:0] row;
        logic [tcw_pkg::COL_W-1:0] col;
        pick = $urandom_range(0, 9);
        row  = tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1));
        col  = tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        if (pick < 2)
            row = ROW_LAST;
        else if (pick == 7)
            row = tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS, 31));
        else if (pick == 8)
            col = tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS, 127));
        else if (pick == 9)
        begin
            row = tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS, 31));
            col = tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS, 127));
        end
        push_item(tcw_pkg::REQ_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), row, col);
    endfunction

    // One line of text: random bytes with reads and noise mixed in, usually ended by a
    // newline. Lengths lean to empty lines (more scrolls) and to lines at or past the
    // width (wrap pending and wrap on the next byte).
    function automatic void queue_line();
        int pick;
        int len;
        logic [tcw_pkg::CHAR_W-1:0] code;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            len = $urandom_range(0, 4);
        else if (pick < 7)
            len = $urandom_range(5, 40);
        else if (pick == 7)
            len = $urandom_range(tcw_pkg::COLUMNS - 4, tcw_pkg::COLUMNS);
        else
            len = $urandom_range(tcw_pkg::COLUMNS - 1, 130);
        for (int i = 0; i < len; i++)
        begin
            code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
            if (code == tcw_pkg::NEWLINE_CODE)
                code = tcw_pkg::SPACE_CODE;
            push_item(tcw_pkg::REQ_PUT, code, tcw_pkg::ROW_W'($urandom_range(0, 31)),
                      tcw_pkg::COL_W'($urandom_range(0, 127)));
            if ($urandom_range(0, 3) == 0)
                queue_read();
            // Noise: any request code with any field contents.
            if ($urandom_range(0, 29) == 0)
                push_item(tcw_pkg::REQ_W'($urandom_range(0, 3)),
                          tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                          tcw_pkg::ROW_W'($urandom_range(0, 31)),
                          tcw_pkg::COL_W'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 4) != 0)
            push_item(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE,
                      tcw_pkg::ROW_W'($urandom_range(0, 31)),
                      tcw_pkg::COL_W'($urandom_range(0, 127)));
        if ($urandom_range(0, 49) == 0)
            push_item(tcw_pkg::REQ_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                      tcw_pkg::ROW_W'($urandom_range(0, 31)),
                      tcw_pkg::COL_W'($urandom_range(0, 127)));
    endfunction

    // Hold off until every request has gone in and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write text_color, then read it back over the same port.
    task automatic cfg_write_check(input logic [tcw_pkg::CHAR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_COLOR_ADDR;
        pwdata  <= tcw_pkg::APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        // Write lands at this edge (pready is always high); turn straight into a read setup.
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[tcw_pkg::CHAR_W-1:0] !== value)
        begin
            $error("text_color: expected %0d, got %0d", value, prdata[tcw_pkg::CHAR_W-1:0]);
            err_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        attr_reg = value;
        n_colors++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    logic [tcw_pkg::CHAR_W-1:0] next_color;

    initial
    begin
        attr_reg = tcw_pkg::RESET_COLOR;
        wipe_screen();
        n_colors = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents at both corners, off-screen reads, byte extremes,
        // the unused code, a newline above the last row, and a clear.
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'hFF, ROW_LAST, COL_LAST);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_OFF, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_OFF);
        push_item(tcw_pkg::REQ_READ, 8'hFF, ROW_MAX, COL_MAX);
        push_item(tcw_pkg::REQ_PUT, 8'h00, ROW_MAX, COL_MAX);
        push_item(tcw_pkg::REQ_PUT, 8'hFF, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, 8'h41, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, tcw_pkg::SPACE_CODE, ROW_ZERO, COL_ZERO);
        push_item(REQ_UNUSED, 8'hFF, ROW_MAX, COL_MAX);
        push_item(REQ_UNUSED, 8'h00, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_ONE);
        push_item(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, 8'h0B, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, 8'h09, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ONE, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_FOUR);
        push_item(tcw_pkg::REQ_CLEAR, 8'hFF, ROW_MAX, COL_MAX);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_PUT, 8'h7E, ROW_ZERO, COL_ZERO);
        push_item(tcw_pkg::REQ_READ, 8'h00, ROW_ZERO, COL_ZERO);
        wait_idle();

        // Random phases, each under its own color; both extremes come first.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                next_color = 8'hFF;
            else if (phase == 1)
                next_color = 8'h00;
            else
                next_color = tcw_pkg::CHAR_W'($urandom_range(0, 255));
            cfg_write_check(next_color);
            calm_pacing = (phase % 4 == 3);
            while (stim_count < PHASE_ITEMS * (phase + 1) + 25)
                queue_line();
            wait_idle();
        end

        // Give a stray result the time of a full scroll to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d puts (%0d newlines), %0d reads (%0d off screen), ",
                 n_puts + n_reads + n_clears + n_unused, n_puts, n_newlines, n_reads,
                 n_reads_off, "%0d clears, %0d unused codes", n_clears, n_unused);
        $display("Saw %0d scrolls and %0d line wraps under %0d text colors; %0d mismatches",
                 n_scrolls, n_wraps, n_colors, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < MAX_CYCLES)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

endmodule
